### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isc assertion failed");

`endif

### rtl/isc_pkg.sv
`timescale 1ns / 1ps

package isc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // fixed field widths of the stream payload
  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 5;
  localparam int CNTF_W    = 5;
  localparam int ST_W      = 2;
  localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + CNTF_W + 7) / 8) * 8;

  // widest index and count over the legal depth range
  localparam int IDX_MAX_W = 8;
  localparam int CNT_MAX_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_INSERT     = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5,
    OP_MAX        = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_kind_t;

  // shift command broadcast to every cell
  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDX_MAX_W-1:0] at;
  } cell_cmd_t;

  // leaf selection for the reduction tree
  typedef struct packed {
    logic                 is_max;
    logic [IDX_MAX_W-1:0] at;
    logic [CNT_MAX_W-1:0] count;
  } scan_t;

endpackage

### rtl/isc_cell.sv
`timescale 1ns / 1ps

module isc_cell #(
  parameter int WIDTH = isc_pkg::WIDTH_DEF,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  isc_pkg::cell_cmd_t cmd,
  input  isc_pkg::scan_t    scan,
  input  logic [WIDTH-1:0]  load_val,
  input  logic [WIDTH-1:0]  left_val,
  input  logic [WIDTH-1:0]  right_val,
  output logic [WIDTH-1:0]  val_q,
  output logic              leaf_valid
);

  localparam logic [isc_pkg::IDX_MAX_W-1:0] IDX = isc_pkg::IDX_MAX_W'(INDEX);

  logic [WIDTH-1:0] val_r;
  logic [WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd.kind)
      isc_pkg::CMD_OPEN: begin
        // later cells move up one place, the target cell takes the new value
        if (IDX > cmd.at) begin
          val_nxt = left_val;
        end else if (IDX == cmd.at) begin
          val_nxt = load_val;
        end
      end
      isc_pkg::CMD_CLOSE: begin
        if (IDX >= cmd.at) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q      = val_r;
  assign leaf_valid = scan.is_max ? ({1'b0, IDX} < scan.count) : (IDX == scan.at);

endmodule

### rtl/isc_max_tree.sv
`timescale 1ns / 1ps

module isc_max_tree #(
  parameter int WIDTH = isc_pkg::WIDTH_DEF,
  parameter int DEPTH = isc_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEPTH-1:0] leaf_valid,
  input  logic [WIDTH-1:0] leaf_val [DEPTH],
  output logic             done,
  output logic             found,
  output logic [WIDTH-1:0] max_val
);

  localparam int LVL = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int N   = 1 << LVL;

  // heap layout: internal nodes 1..N-1, leaves N..2N-1
  logic             hv [1:2*N-1];
  logic [WIDTH-1:0] hd [1:2*N-1];
  logic [LVL-1:0]   vld_r;
  logic [LVL-1:0]   vld_nxt;

  genvar n;
  generate
    for (n = 0; n < N; n++) begin : g_leaf
      if (n < DEPTH) begin : g_used
        assign hv[N+n] = leaf_valid[n];
        assign hd[N+n] = leaf_val[n];
      end else begin : g_pad
        assign hv[N+n] = 1'b0;
        assign hd[N+n] = '0;
      end
    end

    for (n = 1; n < N; n++) begin : g_node
      logic             pick_right;
      logic             nv_r;
      logic [WIDTH-1:0] nd_r;
      assign hv[n] = nv_r;
      assign hd[n] = nd_r;
      // on a tie keep the left child: the lower index wins
      assign pick_right = hv[2*n+1] &&
                          (!hv[2*n] || ($signed(hd[2*n+1]) > $signed(hd[2*n])));
      always_ff @(posedge clk) begin
        nv_r <= hv[2*n] || hv[2*n+1];
        nd_r <= pick_right ? hd[2*n+1] : hd[2*n];
      end
    end
  endgenerate

  assign vld_nxt = LVL'({vld_r, start});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign done    = vld_r[LVL-1];
  assign found   = hv[1];
  assign max_val = hd[1];

endmodule

### rtl/indexed_sequence_store_unit.sv
`timescale 1ns / 1ps
// Push, insert, clear and any refused request complete in the execute state; the unit
// takes a new request only once the previous result is in the output register.
// Pop, remove, read and max also wait for the registered max/select tree over the
// cell row.
// rst_n (synchronous, active low) empties the store; cell contents are not cleared.

module indexed_sequence_store_unit #(
  parameter int DEPTH = isc_pkg::DEPTH_DEF,
  parameter int WIDTH = isc_pkg::WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [isc_pkg::IN_DATA_W-1:0]  in_tdata,   // item_value, position
  input  logic [isc_pkg::OP_W-1:0]       in_tuser,   // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [isc_pkg::OUT_DATA_W-1:0] out_tdata,  // read_value, item_count
  output logic [isc_pkg::ST_W-1:0]       out_tuser   // status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > isc_pkg::POS_W) ? CNT_W : isc_pkg::POS_W;
  localparam int VAL_W = isc_pkg::VAL_W;
  localparam int POS_W = isc_pkg::POS_W;
  localparam int IDX_W = isc_pkg::IDX_MAX_W;
  localparam int OUT_PAD = isc_pkg::OUT_DATA_W - VAL_W - isc_pkg::CNTF_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                        state_r;
  logic                          in_ready_r;
  logic                          out_valid_r;
  logic [isc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [isc_pkg::ST_W-1:0]      out_user_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  isc_pkg::op_t                  op_r;
  logic [WIDTH-1:0]              val_r;
  logic [POS_W-1:0]              pos_r;
  logic [VAL_W-1:0]              res_val_r;
  logic [isc_pkg::CNTF_W-1:0]    res_cnt_r;
  isc_pkg::status_t              res_st_r;

  logic                          full;
  logic                          empty;
  logic [CMP_W-1:0]              pos_c;
  logic [CMP_W-1:0]              cnt_c;
  isc_pkg::status_t              exec_st;
  logic                          exec_open;
  logic                          exec_scan;
  logic                          exec_clear;
  logic [IDX_W-1:0]              open_at;
  logic [IDX_W-1:0]              scan_at;
  logic                          is_close;
  logic                          fin;
  logic                          out_free;
  logic                          out_load;
  logic [VAL_W-1:0]              fin_val;
  isc_pkg::status_t              fin_st;
  logic [isc_pkg::CNTF_W-1:0]    fin_cnt;

  isc_pkg::cell_cmd_t            cmd;
  isc_pkg::scan_t                scan;
  logic [WIDTH-1:0]              cell_q [DEPTH];
  logic [DEPTH-1:0]              leaf_v;
  logic                          tree_start;
  logic                          tree_done;
  logic                          tree_found;
  logic [WIDTH-1:0]              tree_val;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign pos_c = CMP_W'(pos_r);
  assign cnt_c = CMP_W'(count_r);

  // decode the held request against the current count
  always_comb begin
    exec_st    = isc_pkg::ST_OK;
    exec_open  = 1'b0;
    exec_scan  = 1'b0;
    exec_clear = 1'b0;
    open_at    = '0;
    case (op_r)
      isc_pkg::OP_PUSH_BACK: begin
        open_at = IDX_W'(count_r);
        if (full) exec_st = isc_pkg::ST_FULL;
        else      exec_open = 1'b1;
      end
      isc_pkg::OP_PUSH_FRONT: begin
        if (full) exec_st = isc_pkg::ST_FULL;
        else      exec_open = 1'b1;
      end
      isc_pkg::OP_INSERT: begin
        open_at = IDX_W'(pos_r);
        if (full)               exec_st = isc_pkg::ST_FULL;
        else if (pos_c > cnt_c) exec_st = isc_pkg::ST_BADPOS;
        else                    exec_open = 1'b1;
      end
      isc_pkg::OP_POP_FRONT, isc_pkg::OP_MAX: begin
        if (empty) exec_st = isc_pkg::ST_EMPTY;
        else       exec_scan = 1'b1;
      end
      isc_pkg::OP_REMOVE, isc_pkg::OP_READ: begin
        if (empty)               exec_st = isc_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) exec_st = isc_pkg::ST_BADPOS;
        else                     exec_scan = 1'b1;
      end
      isc_pkg::OP_CLEAR: exec_clear = 1'b1;
      default: exec_st = isc_pkg::ST_OK;
    endcase
  end

  assign scan_at  = (op_r == isc_pkg::OP_POP_FRONT) ? '0 : IDX_W'(pos_r);
  assign is_close = (op_r == isc_pkg::OP_POP_FRONT) || (op_r == isc_pkg::OP_REMOVE);

  assign fin      = ((state_r == S_EXEC) && !exec_scan) || ((state_r == S_SCAN) && tree_done);
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (fin || (state_r == S_EMIT)) && out_free;

  always_comb begin
    count_nxt = count_r;
    cmd.kind  = isc_pkg::CMD_HOLD;
    cmd.at    = '0;
    if (state_r == S_EXEC) begin
      if (exec_open) begin
        count_nxt = count_r + 1'b1;
        cmd.kind  = isc_pkg::CMD_OPEN;
        cmd.at    = open_at;
      end else if (exec_clear) begin
        count_nxt = '0;
      end
    end else if ((state_r == S_SCAN) && tree_done && is_close) begin
      count_nxt = count_r - 1'b1;
      cmd.kind  = isc_pkg::CMD_CLOSE;
      cmd.at    = scan_at;
    end
  end

  assign fin_val = ((state_r == S_SCAN) && tree_found) ? VAL_W'(tree_val) : '0;
  assign fin_st  = (state_r == S_SCAN) ? isc_pkg::ST_OK : exec_st;
  assign fin_cnt = isc_pkg::CNTF_W'(count_nxt);

  assign scan.is_max = (op_r == isc_pkg::OP_MAX);
  assign scan.at     = scan_at;
  assign scan.count  = isc_pkg::CNT_MAX_W'(count_r);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_v;
      logic [WIDTH-1:0] right_v;
      if (i > 0) begin : g_left
        assign left_v = cell_q[i-1];
      end else begin : g_first
        assign left_v = val_r;
      end
      if (i < DEPTH - 1) begin : g_right
        assign right_v = cell_q[i+1];
      end else begin : g_last
        assign right_v = cell_q[i];
      end
      isc_cell #(
        .WIDTH (WIDTH),
        .INDEX (i)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .scan       (scan),
        .load_val   (val_r),
        .left_val   (left_v),
        .right_val  (right_v),
        .val_q      (cell_q[i]),
        .leaf_valid (leaf_v[i])
      );
    end
  endgenerate

  assign tree_start = (state_r == S_EXEC) && exec_scan;

  isc_max_tree #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (tree_start),
    .leaf_valid (leaf_v),
    .leaf_val   (cell_q),
    .done       (tree_done),
    .found      (tree_found),
    .max_val    (tree_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_ready_r) begin
            op_r       <= isc_pkg::op_t'(in_tuser);
            val_r      <= WIDTH'($signed(in_tdata[VAL_W-1:0]));
            pos_r      <= in_tdata[VAL_W +: POS_W];
            in_ready_r <= 1'b0;
            state_r    <= S_EXEC;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_EXEC: begin
          if (exec_scan) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // wait for the tree root
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r  <= {OUT_PAD'(0), res_cnt_r, res_val_r};
            out_user_r  <= res_st_r;
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fin) begin
        if (out_free) begin
          out_data_r  <= {OUT_PAD'(0), fin_cnt, fin_val};
          out_user_r  <= fin_st;
          in_ready_r  <= 1'b1;
          state_r     <= S_IDLE;
        end else begin
          // hold the result until the output register drains
          res_val_r <= fin_val;
          res_cnt_r <= fin_cnt;
          res_st_r  <= fin_st;
          state_r   <= S_EMIT;
        end
      end
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/isc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isc_checker #(
  parameter int DEPTH = isc_pkg::DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [isc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [isc_pkg::OP_W-1:0]       in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [isc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [isc_pkg::ST_W-1:0]       out_tuser
);

  localparam int VAL_W  = isc_pkg::VAL_W;
  localparam int CNTF_W = isc_pkg::CNTF_W;

  logic [CNTF_W-1:0] cnt_f;
  logic [VAL_W-1:0]  val_f;
  logic              in_hs;
  logic              refused;

  assign cnt_f   = out_tdata[VAL_W +: CNTF_W];
  assign val_f   = out_tdata[VAL_W-1:0];
  assign in_hs   = in_tvalid && in_tready && (in_tdata == in_tdata) && (in_tuser == in_tuser);
  assign refused = out_tvalid && (out_tuser != isc_pkg::ST_OK);

  `ISC_ASSERT_IMP(a_full_count, clk, rst_n, out_tvalid && (out_tuser == isc_pkg::ST_FULL), cnt_f == CNTF_W'(DEPTH))
  `ISC_ASSERT_IMP(a_empty_count, clk, rst_n, out_tvalid && (out_tuser == isc_pkg::ST_EMPTY), cnt_f == '0)
  `ISC_ASSERT_IMP(a_refused_zero, clk, rst_n, refused, val_f == '0)
  `ISC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_hs, !in_tready)
  `ISC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind indexed_sequence_store_unit isc_checker #(
  .DEPTH (DEPTH)
) u_isc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/indexed_sequence_store_unit_tb.sv
`timescale 1ns / 1ps

module indexed_sequence_store_unit_tb;

  localparam int STORE_DEPTH = isc_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int VAL_W       = isc_pkg::VAL_W;
  localparam int POS_W       = isc_pkg::POS_W;
  localparam int CNTF_W      = isc_pkg::CNTF_W;
  localparam int IN_DATA_W   = isc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = isc_pkg::OUT_DATA_W;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [CNTF_W-1:0] count;
    isc_pkg::status_t  status;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;   // item_value, position
  logic [isc_pkg::OP_W-1:0] in_tuser = isc_pkg::OP_PUSH_BACK;  // operation
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;   // read_value, item_count
  logic [isc_pkg::ST_W-1:0] out_tuser;   // status

  // shadow copy of the sequence, updated when a request is accepted
  logic [VAL_W-1:0] seq_mem [STORE_DEPTH];
  int               seq_len = 0;

  reply_t pending_replies[$];
  int     errors = 0;
  int     stall_cycles = 0;
  int     requests_sent = 0;
  int     status_seen [4] = '{0, 0, 0, 0};
  int     op_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
  bit     calm = 1'b0;

  indexed_sequence_store_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic reply_t apply_request(isc_pkg::op_t op, logic [VAL_W-1:0] val,
                                           logic [POS_W-1:0] pos);
    reply_t           r;
    logic [VAL_W-1:0] best;
    int               at;
    int               k;
    r.value  = '0;
    r.status = isc_pkg::ST_OK;
    case (op)
      isc_pkg::OP_PUSH_BACK, isc_pkg::OP_PUSH_FRONT, isc_pkg::OP_INSERT: begin
        if (seq_len >= STORE_DEPTH) begin
          r.status = isc_pkg::ST_FULL;
        end else if (op == isc_pkg::OP_INSERT && int'(pos) > seq_len) begin
          r.status = isc_pkg::ST_BADPOS;
        end else begin
          at = (op == isc_pkg::OP_PUSH_BACK) ? seq_len :
               (op == isc_pkg::OP_PUSH_FRONT) ? 0 : int'(pos);
          for (k = seq_len; k > at; k--) seq_mem[k] = seq_mem[k-1];
          seq_mem[at] = val;
          seq_len++;
        end
      end
      isc_pkg::OP_POP_FRONT, isc_pkg::OP_REMOVE, isc_pkg::OP_READ: begin
        at = (op == isc_pkg::OP_POP_FRONT) ? 0 : int'(pos);
        if (seq_len == 0) begin
          r.status = isc_pkg::ST_EMPTY;
        end else if (at >= seq_len) begin
          r.status = isc_pkg::ST_BADPOS;
        end else begin
          r.value = seq_mem[at];
          if (op != isc_pkg::OP_READ) begin
            for (k = at; k + 1 < seq_len; k++) seq_mem[k] = seq_mem[k+1];
            seq_len--;
          end
        end
      end
      isc_pkg::OP_MAX: begin
        if (seq_len == 0) begin
          r.status = isc_pkg::ST_EMPTY;
        end else begin
          best = seq_mem[0];
          for (k = 1; k < seq_len; k++)
            if ($signed(seq_mem[k]) > $signed(best)) best = seq_mem[k];
          r.value = best;
        end
      end
      default: seq_len = 0;
    endcase
    r.count = seq_len[CNTF_W-1:0];
    return r;
  endfunction

  // predict on every accepted request; watchdog on handshake activity
  always @(posedge clk) begin
    reply_t pred;
    if (rst_n && in_tvalid && in_tready) begin
      pred = apply_request(isc_pkg::op_t'(in_tuser), in_tdata[VAL_W-1:0],
                           in_tdata[VAL_W +: POS_W]);
      pending_replies.insert(pending_replies.size(), pred);
      status_seen[pred.status]++;
      op_seen[in_tuser]++;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value  = out_tdata[VAL_W-1:0];
      got.count  = out_tdata[VAL_W +: CNTF_W];
      got.status = isc_pkg::status_t'(out_tuser);
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h count=%0d status=%0d",
                 $time, got.value, got.count, got.status);
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (got.value !== want.value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time, want.value, got.value);
        end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t: item_count expected %0d actual %0d", $time, want.count, got.count);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
  end

  task automatic send_request(isc_pkg::op_t op, logic [VAL_W-1:0] val,
                              logic [POS_W-1:0] pos);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - VAL_W - POS_W){1'b0}}, pos, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_request(isc_pkg::OP_CLEAR, 32'h0, 5'd0);
    send_request(isc_pkg::OP_POP_FRONT, 32'h0, 5'd0);
    send_request(isc_pkg::OP_REMOVE, 32'h0, 5'd0);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd0);
    send_request(isc_pkg::OP_MAX, 32'h0, 5'd0);
    send_request(isc_pkg::OP_INSERT, 32'h1111_1111, 5'd1);
    send_request(isc_pkg::OP_INSERT, 32'h0000_0005, 5'd0);
    send_request(isc_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 5'd31);
    send_request(isc_pkg::OP_PUSH_FRONT, 32'h8000_0000, 5'd0);
    send_request(isc_pkg::OP_PUSH_BACK, 32'h0000_0000, 5'd0);
    send_request(isc_pkg::OP_PUSH_BACK, 32'hffff_ffff, 5'd0);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd0);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd2);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd4);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd5);
    send_request(isc_pkg::OP_REMOVE, 32'h0, 5'd16);
    send_request(isc_pkg::OP_MAX, 32'h0, 5'd0);
    send_request(isc_pkg::OP_INSERT, 32'h1234_5678, 5'd5);
    send_request(isc_pkg::OP_INSERT, 32'hdead_beef, 5'd7);
    send_request(isc_pkg::OP_REMOVE, 32'h0, 5'd2);
    send_request(isc_pkg::OP_POP_FRONT, 32'h0, 5'd0);
    send_request(isc_pkg::OP_MAX, 32'h0, 5'd0);
    send_request(isc_pkg::OP_CLEAR, 32'h0, 5'd0);
    send_request(isc_pkg::OP_MAX, 32'h0, 5'd0);
  endtask

  task automatic test_capacity();
    int k;
    send_request(isc_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 5'd0);
    for (k = 1; k < STORE_DEPTH; k++)
      send_request(isc_pkg::OP_PUSH_BACK, pick_value(), 5'd0);
    send_request(isc_pkg::OP_PUSH_BACK, 32'h0000_0001, 5'd0);
    send_request(isc_pkg::OP_PUSH_FRONT, 32'h0000_0002, 5'd0);
    send_request(isc_pkg::OP_INSERT, 32'h0000_0003, 5'd0);
    // full is reported ahead of a bad position
    send_request(isc_pkg::OP_INSERT, 32'h0000_0004, 5'd17);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd15);
    send_request(isc_pkg::OP_READ, 32'h0, 5'd16);
    send_request(isc_pkg::OP_MAX, 32'h0, 5'd0);
    send_request(isc_pkg::OP_REMOVE, 32'h0, 5'd15);
    send_request(isc_pkg::OP_INSERT, 32'h8000_0000, 5'd15);
    send_request(isc_pkg::OP_REMOVE, 32'h0, 5'd0);
    send_request(isc_pkg::OP_INSERT, 32'h8000_0000, 5'd16);
    send_request(isc_pkg::OP_CLEAR, 32'h0, 5'd0);
  endtask

  task automatic test_random(int count);
    int               n;
    int               w;
    isc_pkg::op_t     op;
    logic [POS_W-1:0] pos;
    for (n = 0; n < count; n++) begin
      calm = (n >= count / 5) && (n < count / 5 + 100);
      if (n == count / 2) drain_replies();
      w = $urandom_range(99);
      if (w < 15)      op = isc_pkg::OP_PUSH_BACK;
      else if (w < 27) op = isc_pkg::OP_PUSH_FRONT;
      else if (w < 35) op = isc_pkg::OP_POP_FRONT;
      else if (w < 50) op = isc_pkg::OP_INSERT;
      else if (w < 62) op = isc_pkg::OP_REMOVE;
      else if (w < 82) op = isc_pkg::OP_READ;
      else if (w < 97) op = isc_pkg::OP_MAX;
      else             op = isc_pkg::OP_CLEAR;
      if ($urandom_range(3) == 0)
        pos = POS_W'($urandom_range(16));
      else if (op == isc_pkg::OP_INSERT)
        pos = POS_W'($urandom_range(seq_len));
      else if (seq_len > 0)
        pos = POS_W'($urandom_range(seq_len - 1));
      else
        pos = '0;
      send_request(op, pick_value(), pos);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_random(500);
    drain_replies();
    repeat (30) @(posedge clk);
    $display("sent %0d requests: push %0d, pop %0d, insert %0d, remove %0d, read %0d, max %0d",
             requests_sent,
             op_seen[isc_pkg::OP_PUSH_BACK] + op_seen[isc_pkg::OP_PUSH_FRONT],
             op_seen[isc_pkg::OP_POP_FRONT], op_seen[isc_pkg::OP_INSERT],
             op_seen[isc_pkg::OP_REMOVE], op_seen[isc_pkg::OP_READ],
             op_seen[isc_pkg::OP_MAX]);
    $display("outcomes: ok %0d, full %0d, empty %0d, bad position %0d, clears %0d",
             status_seen[isc_pkg::ST_OK], status_seen[isc_pkg::ST_FULL],
             status_seen[isc_pkg::ST_EMPTY], status_seen[isc_pkg::ST_BADPOS],
             op_seen[isc_pkg::OP_CLEAR]);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
